@@ rtl/tjt_pkg.sv @@
package tjt_pkg;

	localparam int SLOTS_DEF  = 64;
	localparam int MAX_ACTIVE = 64;
	localparam int ID_W       = 32;
	localparam int OP_W       = 4;
	localparam int CMD_W      = 3;
	localparam int STAT_W     = 2;
	localparam int SLOT_W     = 6;
	localparam int ACT_W      = 7;
	localparam logic [ACT_W-1:0] ACT_RESET = 7'd64;

	typedef enum logic [CMD_W-1:0] {
		CMD_BEGIN  = 3'd0,
		CMD_COMMIT = 3'd1,
		CMD_ABORT  = 3'd2,
		CMD_LIST   = 3'd3,
		CMD_CLEAR  = 3'd4,
		CMD_RESCAN = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_EMPTY     = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINAL
	} state_t;

	// One journal entry as held in the slot memory.
	typedef struct packed {
		logic [ID_W-1:0] txn;
		logic [OP_W-1:0] opcode;
		logic [31:0]     inode;
		logic [31:0]     stamp;
	} entry_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic take;
		logic step;
		logic emit_hit;
		logic emit_final;
	} ctl_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic vld_s1;
		logic hit_s1;
		logic last_s1;
		logic scan_end;
		logic out_free;
	} sts_t;

	// Next id after v; the counter skips zero when it wraps.
	function automatic logic [ID_W-1:0] bump(input logic [ID_W-1:0] v);
		logic [ID_W-1:0] n;
		n = v + ID_W'(1);
		return (n == '0) ? ID_W'(1) : n;
	endfunction

endpackage

@@ rtl/tjt_ctrl.sv @@
module tjt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [tjt_pkg::CMD_W-1:0] in_cmd,
	output logic                in_ready,
	input  tjt_pkg::sts_t       sts,
	output tjt_pkg::ctl_t       ctl
);
	import tjt_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (cmd_t'(in_cmd))
						CMD_BEGIN, CMD_COMMIT, CMD_ABORT, CMD_LIST, CMD_RESCAN:
							state_nx = S_SCAN;
						CMD_CLEAR: state_nx = S_FINAL;
						default:   state_nx = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				if (sts.vld_s1 && sts.hit_s1) begin
					if (sts.out_free && sts.last_s1) begin
						state_nx = S_IDLE;
					end
				end else if (sts.scan_end && !sts.vld_s1) begin
					state_nx = S_FINAL;
				end
			end
			S_FINAL: begin
				if (sts.out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ctl      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (cmd_t'(in_cmd))
						CMD_BEGIN, CMD_COMMIT, CMD_ABORT, CMD_LIST, CMD_RESCAN,
						CMD_CLEAR: ctl.take = 1'b1;
						default:   ctl.take = 1'b0;
					endcase
				end
			end
			S_SCAN: begin
				if (sts.vld_s1 && sts.hit_s1) begin
					if (sts.out_free) begin
						ctl.emit_hit = 1'b1;
						ctl.step     = !sts.last_s1;
					end
				end else if (!(sts.scan_end && !sts.vld_s1)) begin
					ctl.step = 1'b1;
				end
			end
			S_FINAL: begin
				ctl.emit_final = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

@@ rtl/tjt_dp.sv @@
module tjt_dp #(
	parameter int SLOTS = tjt_pkg::SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [tjt_pkg::ACT_W-1:0]    cfg_wdata,
	input  logic [tjt_pkg::CMD_W-1:0]    in_cmd,
	input  logic [tjt_pkg::OP_W-1:0]     in_op,
	input  logic [31:0]                  in_inode,
	input  logic [31:0]                  in_stamp,
	input  logic [tjt_pkg::ID_W-1:0]     in_id,
	input  tjt_pkg::ctl_t                ctl,
	output tjt_pkg::sts_t                sts,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [tjt_pkg::STAT_W-1:0]   out_status,
	output logic [tjt_pkg::ID_W-1:0]     out_id,
	output logic [tjt_pkg::OP_W-1:0]     out_operation,
	output logic [31:0]                  out_inode,
	output logic [31:0]                  out_stamp,
	output logic [tjt_pkg::SLOT_W-1:0]   out_slot,
	output logic                         out_last
);
	import tjt_pkg::*;

	// Only the first 64 slots can ever be used, so deeper tables are never written.
	localparam int DEPTH = (SLOTS < MAX_ACTIVE) ? SLOTS : MAX_ACTIVE;
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	entry_t mem [DEPTH];

	logic [ACT_W-1:0] active_q;
	logic [DEPTH-1:0] valid_q, done_q;
	logic [ID_W-1:0]  next_id_q, top_q;

	logic [CMD_W-1:0] cmd_q;
	logic [OP_W-1:0]  op_q;
	logic [31:0]      inode_q, stamp_q;
	logic [ID_W-1:0]  id_q;

	logic [CW-1:0]    idx_q;
	logic [IW-1:0]    idx_s1;
	logic             vld_s1;
	entry_t           rd_s1;

	logic             out_vld_q;
	stat_t            out_stat_q;
	logic [ID_W-1:0]  out_id_q;
	logic [OP_W-1:0]  out_op_q;
	logic [31:0]      out_inode_q, out_stamp_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic             out_last_q;

	logic [CW-1:0]    n_act;
	logic             scan_end, rd_en, occ_s1, match_s1, pend_s1, more_s1, hit_s1;
	logic [DEPTH-1:0] above;
	logic [ID_W-1:0]  rescan_id;

	assign n_act = (active_q > ACT_W'(DEPTH)) ? CW'(DEPTH) : active_q[CW-1:0];
	assign scan_end = (idx_q >= n_act);
	assign rd_en    = ctl.step && !scan_end;

	assign occ_s1   = valid_q[idx_s1];
	assign match_s1 = occ_s1 && (rd_s1.txn == id_q) && (id_q != '0);
	assign pend_s1  = occ_s1 && !done_q[idx_s1];

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			above[i] = (IW'(i) > idx_s1) && (CW'(i) < n_act);
		end
	end
	assign more_s1 = |(valid_q & ~done_q & above);

	always_comb begin
		unique case (cmd_t'(cmd_q))
			CMD_BEGIN:              hit_s1 = !occ_s1;
			CMD_COMMIT, CMD_ABORT:  hit_s1 = match_s1;
			CMD_LIST:               hit_s1 = pend_s1;
			default:                hit_s1 = 1'b0;
		endcase
	end

	assign rescan_id = bump(top_q);

	assign sts.vld_s1   = vld_s1;
	assign sts.hit_s1   = hit_s1;
	assign sts.last_s1  = (cmd_t'(cmd_q) != CMD_LIST) || !more_s1;
	assign sts.scan_end = scan_end;
	assign sts.out_free = !out_vld_q || out_ready;

	// Slot memory: one write port for begin, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (ctl.emit_hit && (cmd_t'(cmd_q) == CMD_BEGIN)) begin
			mem[idx_s1] <= '{txn: next_id_q, opcode: op_q, inode: inode_q, stamp: stamp_q};
		end
		if (rd_en) begin
			rd_s1 <= mem[idx_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cmd_q   <= in_cmd;
			op_q    <= in_op;
			inode_q <= in_inode;
			stamp_q <= in_stamp;
			id_q    <= in_id;
		end
		if (rd_en) begin
			idx_s1 <= idx_q[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= ACT_RESET;
			valid_q   <= '0;
			done_q    <= '0;
			next_id_q <= ID_W'(1);
			top_q     <= '0;
			idx_q     <= '0;
			vld_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			if (ctl.take) begin
				idx_q  <= '0;
				vld_s1 <= 1'b0;
				top_q  <= '0;
			end else if (ctl.step) begin
				vld_s1 <= !scan_end;
				if (!scan_end) begin
					idx_q <= idx_q + CW'(1);
				end
				if (vld_s1 && occ_s1 && (rd_s1.txn > top_q)) begin
					top_q <= rd_s1.txn;
				end
			end
			if (ctl.emit_hit) begin
				unique case (cmd_t'(cmd_q))
					CMD_BEGIN: begin
						valid_q[idx_s1] <= 1'b1;
						done_q[idx_s1]  <= 1'b0;
						next_id_q       <= bump(next_id_q);
					end
					CMD_COMMIT: done_q[idx_s1] <= 1'b1;
					CMD_ABORT: begin
						valid_q[idx_s1] <= 1'b0;
						done_q[idx_s1]  <= 1'b0;
					end
					default: ;
				endcase
			end
			if (ctl.emit_final) begin
				unique case (cmd_t'(cmd_q))
					CMD_CLEAR: begin
						valid_q   <= '0;
						done_q    <= '0;
						next_id_q <= ID_W'(1);
					end
					CMD_RESCAN: next_id_q <= rescan_id;
					default: ;
				endcase
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.emit_hit || ctl.emit_final) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_hit) begin
			out_stat_q <= STAT_OK;
			out_slot_q <= SLOT_W'(idx_s1);
			out_last_q <= (cmd_t'(cmd_q) != CMD_LIST) || !more_s1;
			if (cmd_t'(cmd_q) == CMD_BEGIN) begin
				out_id_q    <= next_id_q;
				out_op_q    <= op_q;
				out_inode_q <= inode_q;
				out_stamp_q <= stamp_q;
			end else begin
				out_id_q    <= rd_s1.txn;
				out_op_q    <= rd_s1.opcode;
				out_inode_q <= rd_s1.inode;
				out_stamp_q <= rd_s1.stamp;
			end
		end else if (ctl.emit_final) begin
			out_id_q    <= '0;
			out_op_q    <= '0;
			out_inode_q <= '0;
			out_stamp_q <= '0;
			out_slot_q  <= '0;
			out_last_q  <= 1'b1;
			unique case (cmd_t'(cmd_q))
				CMD_BEGIN:             out_stat_q <= STAT_FULL;
				CMD_COMMIT, CMD_ABORT: out_stat_q <= STAT_NOT_FOUND;
				CMD_LIST:              out_stat_q <= STAT_EMPTY;
				CMD_CLEAR: begin
					out_stat_q <= STAT_OK;
					out_id_q   <= ID_W'(1);
				end
				CMD_RESCAN: begin
					out_stat_q <= STAT_OK;
					out_id_q   <= rescan_id;
				end
				default: out_stat_q <= STAT_OK;
			endcase
		end
	end

	assign out_valid     = out_vld_q;
	assign out_status    = out_stat_q;
	assign out_id        = out_id_q;
	assign out_operation = out_op_q;
	assign out_inode     = out_inode_q;
	assign out_stamp     = out_stamp_q;
	assign out_slot      = out_slot_q;
	assign out_last      = out_last_q;

endmodule

@@ rtl/transaction_journal_table_core.sv @@
// Transaction journal table.
// Commands arrive on the s_ stream, one beat per command; the command code
// travels in s_tuser, its arguments in s_tdata. Results leave on the m_
// stream: status in m_tuser, entry fields and slot in m_tdata, and m_tlast
// marks the final result beat of a command. Begin, commit, abort, clear and
// rescan give exactly one result beat; list gives one beat per uncommitted
// entry, or a single "no uncommitted entries" beat. Unknown codes are taken
// and dropped without a result.
// The sequencer walks the active slots (at most 64) through the slot memory's
// registered read port, one slot per cycle unless a result waits for the output
// register. Clear skips the scan; begin, commit and abort stop at the first hit.
// The result sits in an output register, so a new command is accepted while
// the previous result still waits; if m_tready is low when another result is
// due, the scan holds its place until the register frees up.
// Reset empties the table, sets the id counter to 1 and the active slot count
// to 64; no clearing pass is needed. cfg_we writes active_slots; the user
// must write it only while idle, as the block itself does not enforce this.
module transaction_journal_table_core #(
	parameter int SLOTS = tjt_pkg::SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration: active_slots.
	input  logic         cfg_we,
	input  logic [6:0]   cfg_wdata,
	// Command stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata, low bit up: operation[3:0], inode_number[35:4], stamp[67:36],
	// txn_id[99:68], zero fill[103:100].
	input  logic [103:0] s_tdata,
	// tuser: cmd[2:0].
	input  logic [2:0]   s_tuser,
	// Result stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata, low bit up: out_id[31:0], out_operation[35:32], out_inode[67:36],
	// out_stamp[99:68], slot_index[105:100], zero fill[111:106].
	output logic [111:0] m_tdata,
	// tuser: status[1:0].
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);
	import tjt_pkg::*;

	ctl_t ctl;
	sts_t sts;

	logic [ID_W-1:0]   res_id;
	logic [OP_W-1:0]   res_op;
	logic [31:0]       res_inode, res_stamp;
	logic [SLOT_W-1:0] res_slot;

	// The sequencer decides when to scan, stall and emit.
	tjt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_cmd   (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// The datapath holds the slot memory, the occupancy and commit flags,
	// the id counter and the output register.
	tjt_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_cmd        (s_tuser),
		.in_op         (s_tdata[3:0]),
		.in_inode      (s_tdata[35:4]),
		.in_stamp      (s_tdata[67:36]),
		.in_id         (s_tdata[99:68]),
		.ctl           (ctl),
		.sts           (sts),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.out_status    (m_tuser),
		.out_id        (res_id),
		.out_operation (res_op),
		.out_inode     (res_inode),
		.out_stamp     (res_stamp),
		.out_slot      (res_slot),
		.out_last      (m_tlast)
	);

	// Bits above the payload are zero fill.
	assign m_tdata = {6'd0, res_slot, res_stamp, res_inode, res_op, res_id};

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import tjt_pkg::*;

	// One command beat as queued for the driver.
	typedef struct {
		logic [2:0]  cmd;
		logic [3:0]  op;
		logic [31:0] inode;
		logic [31:0] stamp;
		logic [31:0] txn;
		bit          hold;  // wait until every result is back before sending
	} journal_cmd_t;

	typedef struct packed {
		stat_t       status;
		logic [31:0] id;
		logic [3:0]  op;
		logic [31:0] inode;
		logic [31:0] stamp;
		logic [5:0]  slot;
		logic        last;
	} journal_beat_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [6:0]   cfg_wdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [103:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	transaction_journal_table_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Shadow journal, updated as each command beat is accepted.
	logic [31:0] jr_txn [64];
	logic        jr_done [64];
	logic [3:0]  jr_op [64];
	logic [31:0] jr_inode [64];
	logic [31:0] jr_stamp [64];
	logic [31:0] jr_next;
	logic [6:0]  jr_active;

	journal_cmd_t  pending_cmds[$];
	journal_beat_t due_results[$];
	journal_cmd_t  beat_cur;
	int unsigned   send_gap = 0;
	int unsigned   stall_left = 0;
	bit            steady = 1'b0;
	int            errors = 0;

	function automatic logic [31:0] id_after(input logic [31:0] v);
		logic [31:0] n;
		n = v + 32'd1;
		return (n == 32'd0) ? 32'd1 : n;
	endfunction

	function automatic journal_beat_t result_beat(input stat_t st, input logic [31:0] id,
			input logic [3:0] op, input logic [31:0] inode, input logic [31:0] stamp,
			input int unsigned slot, input logic last);
		journal_beat_t b;
		b.status = st;
		b.id = id;
		b.op = op;
		b.inode = inode;
		b.stamp = stamp;
		b.slot = slot[5:0];
		b.last = last;
		return b;
	endfunction

	function automatic journal_cmd_t jcmd(input logic [2:0] cmd, input logic [3:0] op,
			input logic [31:0] inode, input logic [31:0] stamp, input logic [31:0] txn);
		journal_cmd_t c;
		c.cmd = cmd;
		c.op = op;
		c.inode = inode;
		c.stamp = stamp;
		c.txn = txn;
		c.hold = 1'b0;
		return c;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r < 9)
			return 0;
		if (r < 15)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Append one expected result beat.
	function automatic void expect_beat(input journal_beat_t b);
		due_results.insert(due_results.size(), b);
	endfunction

	// Append one command for the driver.
	function automatic void queue_cmd(input journal_cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	task automatic journal_clear();
		for (int i = 0; i < 64; i++) begin
			jr_txn[i] = '0;
			jr_done[i] = 1'b0;
			jr_op[i] = '0;
			jr_inode[i] = '0;
			jr_stamp[i] = '0;
		end
		jr_next = 32'd1;
	endtask

	// Apply one command to the shadow journal and queue the beats it yields.
	task automatic journal_step(input journal_cmd_t c);
		int unsigned n;
		int          hit;
		int          tail;
		logic [31:0] top;
		n = (jr_active > 7'd64) ? 64 : jr_active;
		hit = -1;
		case (c.cmd)
			CMD_BEGIN: begin
				for (int i = 0; i < n; i++)
					if (hit < 0 && jr_txn[i] == '0)
						hit = i;
				if (hit < 0) begin
					expect_beat(result_beat(STAT_FULL, 0, 0, 0, 0, 0, 1'b1));
				end else begin
					jr_txn[hit] = jr_next;
					jr_done[hit] = 1'b0;
					jr_op[hit] = c.op;
					jr_inode[hit] = c.inode;
					jr_stamp[hit] = c.stamp;
					expect_beat(result_beat(STAT_OK, jr_next, c.op, c.inode,
						c.stamp, hit, 1'b1));
					jr_next = id_after(jr_next);
				end
			end
			CMD_COMMIT, CMD_ABORT: begin
				// Id zero never matches; duplicates resolve to the lowest slot.
				if (c.txn != '0)
					for (int i = 0; i < n; i++)
						if (hit < 0 && jr_txn[i] == c.txn)
							hit = i;
				if (hit < 0) begin
					expect_beat(result_beat(STAT_NOT_FOUND, 0, 0, 0, 0, 0, 1'b1));
				end else begin
					expect_beat(result_beat(STAT_OK, jr_txn[hit], jr_op[hit],
						jr_inode[hit], jr_stamp[hit], hit, 1'b1));
					if (c.cmd == CMD_COMMIT) begin
						jr_done[hit] = 1'b1;
					end else begin
						jr_txn[hit] = '0;
						jr_done[hit] = 1'b0;
						jr_op[hit] = '0;
						jr_inode[hit] = '0;
						jr_stamp[hit] = '0;
					end
				end
			end
			CMD_LIST: begin
				tail = -1;
				for (int i = 0; i < n; i++)
					if (jr_txn[i] != '0 && !jr_done[i])
						tail = i;
				if (tail < 0)
					expect_beat(result_beat(STAT_EMPTY, 0, 0, 0, 0, 0, 1'b1));
				for (int i = 0; i <= tail; i++)
					if (jr_txn[i] != '0 && !jr_done[i])
						expect_beat(result_beat(STAT_OK, jr_txn[i], jr_op[i],
							jr_inode[i], jr_stamp[i], i, i == tail));
			end
			CMD_CLEAR: begin
				journal_clear();
				expect_beat(result_beat(STAT_OK, jr_next, 0, 0, 0, 0, 1'b1));
			end
			CMD_RESCAN: begin
				top = '0;
				for (int i = 0; i < n; i++)
					if (jr_txn[i] > top)
						top = jr_txn[i];
				jr_next = id_after(top);
				expect_beat(result_beat(STAT_OK, jr_next, 0, 0, 0, 0, 1'b1));
			end
			default: begin
				// Codes six and seven are swallowed without a result.
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
	endtask

	// Commit and abort mostly aim at ids that are live or about to be.
	function automatic logic [31:0] pick_txn();
		logic [31:0] live[$];
		int unsigned n;
		int unsigned r;
		n = (jr_active > 7'd64) ? 64 : jr_active;
		for (int i = 0; i < n; i++)
			if (jr_txn[i] != '0)
				live.insert(live.size(), jr_txn[i]);
		r = $urandom_range(0, 9);
		if (r < 5 && live.size() != 0)
			return live[$urandom_range(0, live.size() - 1)];
		if (r < 7)
			return jr_next + $urandom_range(0, 3);
		if (r == 7)
			return 32'd0;
		if (r == 8)
			return $urandom;
		return $urandom_range(1, jr_next + 2);
	endfunction

	function automatic journal_cmd_t random_cmd();
		journal_cmd_t c;
		int unsigned  r;
		r = $urandom_range(0, 99);
		c = jcmd(CMD_BEGIN, 4'($urandom_range(0, 15)), $urandom, $urandom, $urandom);
		if (r < 36)
			c.cmd = CMD_BEGIN;
		else if (r < 52)
			c.cmd = CMD_COMMIT;
		else if (r < 68)
			c.cmd = CMD_ABORT;
		else if (r < 78)
			c.cmd = CMD_LIST;
		else if (r < 81)
			c.cmd = CMD_CLEAR;
		else if (r < 89)
			c.cmd = CMD_RESCAN;
		else if (r < 94)
			c.cmd = 3'($urandom_range(6, 7));
		if (c.cmd == CMD_COMMIT || c.cmd == CMD_ABORT)
			c.txn = pick_txn();
		c.hold = ($urandom_range(0, 39) == 0);
		return c;
	endfunction

	// Let the block drain completely, including any command that yields no beat.
	task automatic settle_block();
		while (pending_cmds.size() != 0 || s_tvalid || due_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_active(input logic [6:0] v);
		settle_block();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		jr_active = v;
	endtask

	task automatic run_random(input logic [6:0] act, input int count, input bit calm,
			input bit pause_first);
		journal_cmd_t c;
		set_active(act);
		steady = calm;
		for (int i = 0; i < count; i++) begin
			// Keep the queue short so that id choices track the shadow journal.
			while (pending_cmds.size() >= 2)
				@(posedge clk);
			c = random_cmd();
			if (i == 0 && pause_first)
				c.hold = 1'b1;
			queue_cmd(c);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Driver: presents the next pending command whenever the bus is free.
	always @(posedge clk) begin : drive_side
		bit free;
		if (arst_n) begin
			free = !s_tvalid || s_tready;
			if (s_tvalid && s_tready)
				journal_step(beat_cur);
			if (free) begin
				if (send_gap != 0) begin
					send_gap = send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_cmds.size() != 0 &&
						(!pending_cmds[0].hold || due_results.size() == 0)) begin
					beat_cur = pending_cmds.pop_front();
					s_tdata <= {4'b0, beat_cur.txn, beat_cur.stamp, beat_cur.inode, beat_cur.op};
					s_tuser <= beat_cur.cmd;
					s_tvalid <= 1'b1;
					send_gap = steady ? 0 : pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result beat against the oldest expectation.
	always @(posedge clk) begin : sink_side
		journal_beat_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					report_mismatch("unexpected result beat, out_id", m_tdata[31:0], 32'd0);
				end else begin
					want = due_results.pop_front();
					if (m_tuser !== want.status)
						report_mismatch("status", m_tuser, want.status);
					if (m_tdata[31:0] !== want.id)
						report_mismatch("out_id", m_tdata[31:0], want.id);
					if (m_tdata[35:32] !== want.op)
						report_mismatch("out_operation", m_tdata[35:32], want.op);
					if (m_tdata[67:36] !== want.inode)
						report_mismatch("out_inode", m_tdata[67:36], want.inode);
					if (m_tdata[99:68] !== want.stamp)
						report_mismatch("out_stamp", m_tdata[99:68], want.stamp);
					if (m_tdata[105:100] !== want.slot)
						report_mismatch("slot_index", m_tdata[105:100], want.slot);
					if (m_tdata[111:106] !== 6'd0)
						report_mismatch("tdata fill", m_tdata[111:106], 32'd0);
					if (m_tlast !== want.last)
						report_mismatch("tlast", m_tlast, want.last);
				end
			end
			if (stall_left != 0) begin
				stall_left = stall_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!steady && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	initial begin : main_flow
		logic [6:0] act;
		journal_cmd_t c;
		journal_clear();
		jr_active = ACT_RESET;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extremes, repeat commit, abort and reuse, id zero,
		// unknown codes, a clear, then list and rescan on the emptied table.
		queue_cmd(jcmd(CMD_LIST, 0, 0, 0, 0));
		queue_cmd(jcmd(CMD_COMMIT, 0, 0, 0, 32'd0));
		queue_cmd(jcmd(CMD_ABORT, 0, 0, 0, 32'hffff_ffff));
		queue_cmd(jcmd(CMD_BEGIN, 4'h0, 32'h0, 32'h0, 32'h0));
		queue_cmd(jcmd(CMD_BEGIN, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 0));
		queue_cmd(jcmd(CMD_BEGIN, 4'h5, $urandom, $urandom, 0));
		queue_cmd(jcmd(CMD_COMMIT, 0, 0, 0, 32'd2));
		queue_cmd(jcmd(CMD_COMMIT, 0, 0, 0, 32'd2));
		queue_cmd(jcmd(CMD_LIST, 0, 0, 0, 0));
		queue_cmd(jcmd(CMD_ABORT, 0, 0, 0, 32'd1));
		queue_cmd(jcmd(CMD_BEGIN, 4'ha, $urandom, $urandom, 0));
		queue_cmd(jcmd(CMD_RESCAN, 0, 0, 0, 0));
		queue_cmd(jcmd(3'd6, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
		queue_cmd(jcmd(3'd7, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 32'd1));
		queue_cmd(jcmd(CMD_COMMIT, 0, 0, 0, 32'd0));
		queue_cmd(jcmd(CMD_CLEAR, 0, 0, 0, 0));
		queue_cmd(jcmd(CMD_LIST, 0, 0, 0, 0));
		queue_cmd(jcmd(CMD_RESCAN, 0, 0, 0, 0));
		c = jcmd(CMD_BEGIN, 4'h1, $urandom, $urandom, 0);
		c.hold = 1'b1;
		queue_cmd(c);
		queue_cmd(jcmd(CMD_BEGIN, 4'h2, $urandom, $urandom, 0));
		queue_cmd(jcmd(CMD_BEGIN, 4'h3, $urandom, $urandom, 0));

		// Shrink the table: the rescan ignores slot two, so a begin hands out an
		// id that the hidden slot already holds. Growing again exposes the
		// duplicate, and commit and abort pick the lowest slot first.
		set_active(7'd2);
		queue_cmd(jcmd(CMD_RESCAN, 0, 0, 0, 0));
		queue_cmd(jcmd(CMD_ABORT, 0, 0, 0, 32'd1));
		queue_cmd(jcmd(CMD_BEGIN, 4'h7, $urandom, $urandom, 0));
		queue_cmd(jcmd(CMD_BEGIN, 4'h8, $urandom, $urandom, 0));
		set_active(7'd64);
		queue_cmd(jcmd(CMD_COMMIT, 0, 0, 0, 32'd3));
		queue_cmd(jcmd(CMD_ABORT, 0, 0, 0, 32'd3));
		queue_cmd(jcmd(CMD_ABORT, 0, 0, 0, 32'd3));
		queue_cmd(jcmd(CMD_LIST, 0, 0, 0, 0));

		for (int p = 0; p < 12; p++) begin
			case (p)
				0: act = 7'd1;
				1: act = 7'd4;
				2: act = 7'd0;
				3: act = 7'd127;
				4: act = 7'd8;
				5: act = 7'd64;
				6: act = 7'd100;
				7: act = 7'd3;
				8: act = 7'd16;
				9: act = 7'd64;
				10: act = 7'($urandom_range(1, 64));
				default: act = 7'd2;
			endcase
			run_random(act, 40, p == 5 || p == 9, p == 3);
		end

		while (pending_cmds.size() != 0 || s_tvalid || due_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (due_results.size() != 0)
			report_mismatch("results still outstanding", due_results.size(), 32'd0);
		if (errors == 0)
			$display("[transaction_journal_table_core] OK");
		else
			$display("[transaction_journal_table_core] ERROR");
		$finish;
	end

	initial begin : watchdog
		#200_000_000;
		$display("[transaction_journal_table_core] ERROR");
		$finish;
	end

endmodule
